@@ rtl/core/rcpw_pkg.sv @@
package rcpw_pkg;

  localparam int NUM_CH    = 3;
  localparam int CH_STEER  = 0;
  localparam int CH_SPEED  = 1;
  localparam int CH_BUTTON = 2;

  localparam int TIME_W  = 32;
  localparam int WIDTH_W = 16;
  localparam int DZ_W    = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 16'd200;

  // register index is paddr[2], byte offset below it
  localparam logic REG_DEAD_ZONE = 1'b0;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef struct packed {
    logic               fall;
    logic [TIME_W-1:0]  diff;
    logic [WIDTH_W-1:0] prev_width;
  } rcpw_fall_t;

endpackage

@@ rtl/core/rcpw_chan.sv @@
module rcpw_chan
  import rcpw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               level,
  input  logic [TIME_W-1:0]  now,
  output logic               level_nx,
  output logic [WIDTH_W-1:0] width_nx,
  output rcpw_fall_t         fall_ev
);

  logic               level_q;
  logic [TIME_W-1:0]  stamp;
  logic [WIDTH_W-1:0] width;
  logic [TIME_W-1:0]  stamp_next;
  logic [TIME_W-1:0]  diff;
  logic               rise;
  logic               fall;

  assign diff = now - stamp;
  assign rise = en && level && !level_q;
  assign fall = en && !level && level_q;

  always_comb begin
    level_nx   = level_q;
    width_nx   = width;
    stamp_next = stamp;
    if (rise) begin
      level_nx   = 1'b1;
      stamp_next = now;
    end else if (fall) begin
      level_nx = 1'b0;
      width_nx = diff[WIDTH_W-1:0];
    end
  end

  assign fall_ev.fall       = fall;
  assign fall_ev.diff       = diff;
  assign fall_ev.prev_width = width;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_q <= 1'b0;
      stamp   <= '0;
      width   <= '0;
    end else begin
      level_q <= level_nx;
      stamp   <= stamp_next;
      width   <= width_nx;
    end
  end

endmodule

@@ rtl/core/rcpw_press.sv @@
module rcpw_press
  import rcpw_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            query_en,
  input  rcpw_fall_t      fall_ev,
  input  logic [DZ_W-1:0] dead_zone,
  output logic            pressed
);

  logic              flag;
  logic              flag_next;
  logic [TIME_W-1:0] p32;
  logic [TIME_W-1:0] dz32;
  logic [TIME_W-1:0] upper;
  logic [TIME_W-1:0] lower;

  assign p32   = {{(TIME_W-WIDTH_W){1'b0}}, fall_ev.prev_width};
  assign dz32  = {{(TIME_W-DZ_W){1'b0}}, dead_zone};
  // both bounds wrap modulo 2^32
  assign upper = fall_ev.diff + dz32;
  assign lower = fall_ev.diff - dz32;

  always_comb begin
    flag_next = flag;
    if (query_en) begin
      flag_next = 1'b0;
    end else if (fall_ev.fall) begin
      if (p32 < dz32) begin
        flag_next = 1'b0;
      end else if ((p32 > upper) || (p32 < lower)) begin
        flag_next = 1'b1;
      end
    end
  end

  assign pressed = query_en & flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else begin
      flag <= flag_next;
    end
  end

endmodule

@@ rtl/core/rc_pulse_width_capture_3ch_unit.sv @@
// a request passes the input register and then the result register before its result is valid
// throughput: one request per cycle unless the result side stalls; the state update
//   for a request is done in the single combinational pass between the two registers
// reset: synchronous active-high rst clears levels, edge stamps, widths and the press
//   flag, empties both registers and sets dead_zone to 200
module rc_pulse_width_capture_3ch_unit
  import rcpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // s_tdata: [2:0] pin_levels, [34:3] time_us, [39:35] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: [0] func
  input  logic                   s_tuser,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // m_tdata: [15:0] steer_width, [31:16] speed_width, [47:32] button_width,
  //          [50:48] channel_high, [51] button_pressed, [55:52] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic [DZ_W-1:0]    dead_zone;
  logic               in_valid;
  logic               in_func;
  logic [NUM_CH-1:0]  in_pins;
  logic [TIME_W-1:0]  in_time;
  logic               advance;
  logic               sample_en;
  logic               query_en;
  logic [NUM_CH-1:0]  level_nx;
  logic [WIDTH_W-1:0] width_nx [NUM_CH];
  rcpw_fall_t         fall_ev [NUM_CH];
  logic               pressed;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEAD_ZONE)) begin
      dead_zone <= pwdata[DZ_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEAD_ZONE) ? {{(PDATA_W-DZ_W){1'b0}}, dead_zone} : '0;

  // input register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_pins <= s_tdata[NUM_CH-1:0];
      in_time <= s_tdata[NUM_CH+TIME_W-1:NUM_CH];
    end
  end

  assign sample_en = advance && (in_func == FUNC_SAMPLE);
  assign query_en  = advance && (in_func == FUNC_QUERY);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
    rcpw_chan u_chan (
      .clk      (clk),
      .rst      (rst),
      .en       (sample_en),
      .level    (in_pins[c]),
      .now      (in_time),
      .level_nx (level_nx[c]),
      .width_nx (width_nx[c]),
      .fall_ev  (fall_ev[c])
    );
  end

  rcpw_press u_press (
    .clk       (clk),
    .rst       (rst),
    .query_en  (query_en),
    .fall_ev   (fall_ev[CH_BUTTON]),
    .dead_zone (dead_zone),
    .pressed   (pressed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_TDATA_W-3*WIDTH_W-NUM_CH-1){1'b0}}, pressed, level_nx,
                  width_nx[CH_BUTTON], width_nx[CH_SPEED], width_nx[CH_STEER]};
    end
  end

endmodule

@@ rtl/core/rcpw_checker.sv @@
module rcpw_checker
  import rcpw_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // a new result only appears after an accepted request
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching request");

endmodule

bind rc_pulse_width_capture_3ch_unit rcpw_checker u_rcpw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
